// File: sv/btb2l_pkg.sv
// shared types, constants and helpers of the two-level branch target buffer
package btb2l_pkg;

  // default sizes of the storage
  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_MAX_HISTORY = 8;

  // fixed field widths
  localparam int PC_W       = 32;
  localparam int TAG_W      = 30;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 3;

  // pc bit positions and steps
  localparam int          PC_IDX_LSB   = 2;
  localparam int          SHARE_HI_LSB = 16;
  localparam logic [31:0] PC_STEP      = 32'd4;

  // two-bit counter levels
  localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
  localparam logic [1:0] CTR_MAX       = 2'd3;
  localparam logic [1:0] CTR_MIN       = 2'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CTR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_HISTORY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_TABLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE     = 3'd6;

  // share modes
  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_LO   = 2'd1;
  localparam logic [1:0] SHARE_HI   = 2'd2;

  // item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  // operations of the shared arithmetic unit
  typedef enum logic {
    ALU_ADD,
    ALU_NE
  } alu_op_e;

  // input item
  typedef struct packed {
    logic        kind;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dst;
  } bp_in_t;

  // result item
  typedef struct packed {
    logic        predict_taken;
    logic [31:0] next_pc;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } bp_out_t;

  // floor of log2, capped at ten index bits
  function automatic int flog2(input int n);
    int k;
    k = 0;
    for (int i = 0; i < 10; i++) begin
      if ((1 << (k + 1)) <= n) begin
        k = k + 1;
      end
    end
    return k;
  endfunction

endpackage

// File: sv/btb2l_alu.sv
// shared 32-bit add and not-equal unit used by the sequencer
module btb2l_alu
  import btb2l_pkg::*;
(
  input  alu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);

  // one operation per cycle
  always_comb begin
    case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_NE:  res_o = {31'd0, (a_i != b_i)};
      default: res_o = a_i + b_i;
    endcase
  end

endmodule

// File: sv/btb_two_level_branch_predictor_top.sv
// top level of the two-level branch predictor with target buffer
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  item in | start, busy            | item_i (bp_in_t)
//  result  | done_o (one-cycle)     | result_o (bp_out_t)
//  config  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// a predict item passes the read and predict states before the result strobe, an
// update the read, compare, branch count, flush count and write states; the shared
// unit does one add or compare a cycle. reset and any write to a known register
// (index up to REG_SHARE_MODE) clear valid bits, histories, row-valid bits
// of the counter store and the statistics; no clearing pass is needed.
// a result is shown for one cycle and cannot be held off; start is taken
// again in the cycle the result is shown.
module btb_two_level_branch_predictor_top
  import btb2l_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_HISTORY = DEF_MAX_HISTORY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bp_in_t                item_i,
  output logic                  done_o,
  output bp_out_t               result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IB_MAX  = flog2(MAX_ENTRIES);
  localparam int IDX_W   = (IB_MAX > 0) ? IB_MAX : 1;
  localparam int ENTRIES = 1 << IB_MAX;
  localparam int HIST_W  = MAX_HISTORY;
  localparam int COLS    = 1 << MAX_HISTORY;
  localparam int ROW_W   = 2 * COLS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_BCNT = 3'd3;
  localparam logic [2:0] ST_FCNT = 3'd4;
  localparam logic [2:0] ST_PRED = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;

  // configuration registers
  logic [2:0] index_bits_q;
  logic [3:0] history_length_q;
  logic [4:0] tag_bits_q;
  logic [1:0] initial_ctr_q;
  logic       global_history_q;
  logic       global_table_q;
  logic [1:0] share_mode_q;
  logic       cfg_hit;

  // control and statistics
  logic [2:0]  state_q, state_d;
  logic [31:0] branch_cnt_q;
  logic [31:0] flush_cnt_q;
  logic        done_q;

  // item payload and working values
  bp_in_t      item_q;
  logic [31:0] pc4_q;
  logic        mis_q;
  bp_out_t     result_q;

  // flop state
  logic [ENTRIES-1:0]             valid_q;
  logic [ENTRIES-1:0]             row_vld_q;
  logic [ENTRIES-1:0][HIST_W-1:0] hist_q;

  // memories and their registered read data
  logic [TAG_W-1:0] tag_mem [ENTRIES];
  logic [31:0]      tgt_mem [ENTRIES];
  logic [ROW_W-1:0] row_mem [ENTRIES];
  logic [TAG_W-1:0] tag_rd_q;
  logic [31:0]      tgt_rd_q;
  logic [ROW_W-1:0] row_rd_q;

  // shared unit
  alu_op_e     alu_op;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [31:0] alu_res;

  // address and selection logic
  logic [3:0]        ib_eff;
  logic [IDX_W-1:0]  idx_mask;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  ridx;
  logic [IDX_W-1:0]  hidx;
  logic [4:0]        tag_sh;
  logic [31:0]       pc_sh;
  logic [TAG_W-1:0]  tag_mask;
  logic [TAG_W-1:0]  tag;
  logic              hit;
  logic              upd_miss;
  logic [3:0]        hlen_eff;
  logic [HIST_W-1:0] hm;
  logic [HIST_W-1:0] hist_eff;
  logic [HIST_W-1:0] xor_bits;
  logic [HIST_W-1:0] col;
  logic [HIST_W-1:0] hist_new;
  logic [ROW_W-1:0]  row_eff;
  logic [ROW_W-1:0]  row_new;
  logic [1:0]        ctr;
  logic [1:0]        ctr_new;
  logic              pred_taken;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_SHARE_MODE);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q     <= 3'd5;
      history_length_q <= 4'd8;
      tag_bits_q       <= 5'd30;
      initial_ctr_q    <= 2'd1;
      global_history_q <= 1'b0;
      global_table_q   <= 1'b0;
      share_mode_q     <= SHARE_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INDEX_BITS:     index_bits_q     <= cfg_data_i[2:0];
        REG_HISTORY_LENGTH: history_length_q <= cfg_data_i[3:0];
        REG_TAG_BITS:       tag_bits_q       <= cfg_data_i[4:0];
        REG_INITIAL_CTR:    initial_ctr_q    <= cfg_data_i[1:0];
        REG_GLOBAL_HISTORY: global_history_q <= cfg_data_i[0];
        REG_GLOBAL_TABLE:   global_table_q   <= cfg_data_i[0];
        REG_SHARE_MODE:     share_mode_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // index and tag from the held pc
  always_comb begin
    ib_eff   = (4'(index_bits_q) > 4'(IB_MAX)) ? 4'(IB_MAX) : 4'(index_bits_q);
    idx_mask = ~({IDX_W{1'b1}} << ib_eff);
    idx      = item_q.pc[PC_IDX_LSB +: IDX_W] & idx_mask;
    ridx     = global_table_q ? '0 : idx;
    hidx     = global_history_q ? '0 : idx;
    tag_sh   = 5'(PC_IDX_LSB) + 5'(ib_eff);
    pc_sh    = item_q.pc >> tag_sh;
    tag_mask = (tag_bits_q >= 5'(TAG_W)) ? {TAG_W{1'b1}} : ~({TAG_W{1'b1}} << tag_bits_q);
    tag      = pc_sh[TAG_W-1:0] & tag_mask;
    hit      = valid_q[idx] && (tag_rd_q == tag);
    upd_miss = (item_q.kind == KIND_UPDATE) && !hit;
  end

  // counter slot selection and training
  always_comb begin
    hlen_eff = (history_length_q > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : history_length_q;
    hm       = ~({HIST_W{1'b1}} << hlen_eff);
    hist_eff = (upd_miss && !global_history_q) ? '0 : hist_q[hidx];
    case (share_mode_q)
      SHARE_LO: xor_bits = item_q.pc[PC_IDX_LSB +: HIST_W];
      SHARE_HI: xor_bits = item_q.pc[SHARE_HI_LSB +: HIST_W];
      default:  xor_bits = '0;
    endcase
    col = (hist_eff ^ xor_bits) & hm;
    if (!row_vld_q[ridx] || (upd_miss && !global_table_q)) begin
      row_eff = {COLS{initial_ctr_q}};
    end else begin
      row_eff = row_rd_q;
    end
    ctr = row_eff[{col, 1'b0} +: 2];
    if (item_q.taken) begin
      ctr_new = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
    end else begin
      ctr_new = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
    end
    row_new = row_eff;
    row_new[{col, 1'b0} +: 2] = ctr_new;
    hist_new   = ((hist_eff << 1) & hm) | {{(HIST_W-1){1'b0}}, item_q.taken};
    pred_taken = hit && (ctr >= CTR_TAKEN_MIN);
  end

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      ST_READ: begin
        alu_a = item_q.pc;
        alu_b = PC_STEP;
      end
      ST_CMP: begin
        alu_op = ALU_NE;
        alu_a  = item_q.predicted_dst;
        alu_b  = item_q.taken ? item_q.target_pc : pc4_q;
      end
      ST_BCNT: begin
        alu_a = branch_cnt_q;
        alu_b = 32'd1;
      end
      ST_FCNT: begin
        alu_a = flush_cnt_q;
        alu_b = {31'd0, mis_q};
      end
      default: ;
    endcase
  end

  btb2l_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_READ;
      ST_READ: state_d = (item_q.kind == KIND_UPDATE) ? ST_CMP : ST_PRED;
      ST_CMP:  state_d = ST_BCNT;
      ST_BCNT: state_d = ST_FCNT;
      ST_FCNT: state_d = ST_UPD;
      ST_PRED: state_d = ST_IDLE;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, statistics and flop tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_q       <= 1'b0;
      branch_cnt_q <= '0;
      flush_cnt_q  <= '0;
      valid_q      <= '0;
      row_vld_q    <= '0;
      hist_q       <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_PRED) || (state_q == ST_UPD);
      if (cfg_hit) begin
        branch_cnt_q <= '0;
        flush_cnt_q  <= '0;
        valid_q      <= '0;
        row_vld_q    <= '0;
        hist_q       <= '0;
      end else begin
        if (state_q == ST_BCNT) begin
          branch_cnt_q <= alu_res;
        end
        if (state_q == ST_FCNT) begin
          flush_cnt_q <= alu_res;
        end
        if (state_q == ST_UPD) begin
          valid_q[idx]    <= 1'b1;
          row_vld_q[ridx] <= 1'b1;
          hist_q[hidx]    <= hist_new;
        end
      end
    end
  end

  // item payload, working values and result
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      item_q <= item_i;
    end
    if (state_q == ST_READ) begin
      pc4_q <= alu_res;
    end
    if (state_q == ST_CMP) begin
      mis_q <= alu_res[0];
    end
    if (state_q == ST_PRED) begin
      result_q.predict_taken <= pred_taken;
      result_q.next_pc       <= pred_taken ? tgt_rd_q : pc4_q;
      result_q.branch_count  <= branch_cnt_q;
      result_q.flush_count   <= flush_cnt_q;
    end
    if (state_q == ST_UPD) begin
      result_q.predict_taken <= 1'b0;
      result_q.next_pc       <= '0;
      result_q.branch_count  <= branch_cnt_q;
      result_q.flush_count   <= flush_cnt_q;
    end
  end

  // tag, target and counter-row memories
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      tag_rd_q <= tag_mem[idx];
      tgt_rd_q <= tgt_mem[idx];
      row_rd_q <= row_mem[ridx];
    end
    if (state_q == ST_UPD) begin
      tag_mem[idx]  <= tag;
      tgt_mem[idx]  <= item_q.target_pc;
      row_mem[ridx] <= row_new;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // a result strobe lasts one cycle and lands with the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_IDLE && !$past(done_o)))
    else $error("result strobe outside idle or longer than one cycle");

  // update results carry no prediction
  a_upd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && !cfg_hit) |=> (done_o && !result_o.predict_taken
                                        && result_o.next_pc == 32'd0))
    else $error("update result carries a prediction");

  // branch count steps by exactly one per update
  a_bcnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BCNT && !cfg_hit) |=> (branch_cnt_q == $past(branch_cnt_q) + 32'd1))
    else $error("branch count did not step by one");

  // the flush count moves only in its own step
  a_fcnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FCNT && !cfg_hit) |=> $stable(flush_cnt_q))
    else $error("flush count changed outside its step");

endmodule

// File: bench/btb_two_level_branch_predictor_checker.sv
// checker: watches item, result and config channels, predicts results and compares them
module btb_two_level_branch_predictor_checker
  import btb2l_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  bp_in_t                item_i,
  input  logic                  done_i,
  input  bp_out_t               result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  localparam int ENTRIES = DEF_MAX_ENTRIES;
  localparam int HIST_W  = DEF_MAX_HISTORY;
  localparam int ROW     = 1 << HIST_W;
  localparam int IDX_CAP = $clog2(ENTRIES);

  // configuration copy
  logic [2:0] r_index_bits;
  logic [3:0] r_hist_len;
  logic [4:0] r_tag_bits;
  logic [1:0] r_init_ctr;
  logic       r_global_hist;
  logic       r_global_tbl;
  logic [1:0] r_share;

  // predictor tables
  logic              valid_m  [ENTRIES];
  logic [TAG_W-1:0]  tag_m    [ENTRIES];
  logic [PC_W-1:0]   target_m [ENTRIES];
  logic [HIST_W-1:0] hist_m   [ENTRIES];
  logic [1:0]        ctr_m    [ENTRIES*ROW];
  logic [31:0]       branches;
  logic [31:0]       flushes;

  bp_out_t     outcome_q [$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  // back to power-up contents under the current configuration
  task automatic wipe_tables();
    for (int e = 0; e < ENTRIES; e++) begin
      valid_m[e]  = 1'b0;
      tag_m[e]    = '0;
      target_m[e] = '0;
      hist_m[e]   = '0;
    end
    for (int s = 0; s < ENTRIES*ROW; s++) begin
      ctr_m[s] = r_init_ctr;
    end
    branches = '0;
    flushes  = '0;
  endtask

  task automatic set_defaults();
    r_index_bits  = 3'd5;
    r_hist_len    = 4'd8;
    r_tag_bits    = 5'd30;
    r_init_ctr    = 2'd1;
    r_global_hist = 1'b0;
    r_global_tbl  = 1'b0;
    r_share       = SHARE_NONE;
    wipe_tables();
  endtask

  // any known register write reinitializes the tables
  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] ri,
                                 input logic [CFG_DATA_W-1:0] d);
    logic known;
    known = 1'b1;
    case (ri)
      REG_INDEX_BITS:     r_index_bits  = d[2:0];
      REG_HISTORY_LENGTH: r_hist_len    = d[3:0];
      REG_TAG_BITS:       r_tag_bits    = d[4:0];
      REG_INITIAL_CTR:    r_init_ctr    = d[1:0];
      REG_GLOBAL_HISTORY: r_global_hist = d[0];
      REG_GLOBAL_TABLE:   r_global_tbl  = d[0];
      REG_SHARE_MODE:     r_share       = d[1:0];
      default:            known         = 1'b0;
    endcase
    if (known) begin
      wipe_tables();
    end
  endtask

  function automatic int unsigned used_index_bits();
    return (r_index_bits > IDX_CAP) ? IDX_CAP : r_index_bits;
  endfunction

  function automatic logic [31:0] hist_mask();
    int unsigned hl;
    hl = (r_hist_len > HIST_W) ? HIST_W : r_hist_len;
    return (32'd1 << hl) - 32'd1;
  endfunction

  // counter selected by history, optionally folded with pc bits
  function automatic int unsigned ctr_slot(input int unsigned idx, input logic [31:0] pc);
    logic [31:0] hm;
    logic [31:0] col;
    int unsigned row;
    hm  = hist_mask();
    col = 32'(hist_m[r_global_hist ? 0 : idx]);
    row = r_global_tbl ? 0 : idx;
    case (r_share)
      SHARE_LO: col = col ^ ((pc >> PC_IDX_LSB) & hm);
      SHARE_HI: col = col ^ ((pc >> SHARE_HI_LSB) & hm);
      default: ;
    endcase
    return row * ROW + (col & hm);
  endfunction

  // next expected result for one item, tables updated as a side effect
  task automatic resolve_item(input bp_in_t it, output bp_out_t res);
    int unsigned ib;
    int unsigned idx;
    int unsigned slot;
    int unsigned hrow;
    int unsigned tbits;
    logic [63:0] tmask;
    logic [31:0] tag;
    logic [31:0] pc4;
    logic [31:0] hm;
    logic        hit;
    logic [1:0]  c;
    ib    = used_index_bits();
    idx   = (it.pc >> PC_IDX_LSB) & ((1 << ib) - 1);
    tbits = (r_tag_bits > TAG_W) ? TAG_W : r_tag_bits;
    tmask = (64'd1 << tbits) - 64'd1;
    tag   = (it.pc >> (PC_IDX_LSB + ib)) & tmask[31:0];
    hit   = valid_m[idx] && (tag_m[idx] == tag[TAG_W-1:0]);
    pc4   = it.pc + PC_STEP;
    res   = '0;
    if (it.kind == KIND_PREDICT) begin
      res.next_pc = pc4;
      if (hit && ctr_m[ctr_slot(idx, it.pc)] >= CTR_TAKEN_MIN) begin
        res.predict_taken = 1'b1;
        res.next_pc       = target_m[idx];
      end
    end else begin
      branches = branches + 32'd1;
      if ((it.taken && it.predicted_dst != it.target_pc) ||
          (!it.taken && it.predicted_dst != pc4)) begin
        flushes = flushes + 32'd1;
      end
      // install on miss
      if (!hit) begin
        valid_m[idx] = 1'b1;
        tag_m[idx]   = tag[TAG_W-1:0];
        if (!r_global_hist) begin
          hist_m[idx] = '0;
        end
        if (!r_global_tbl) begin
          for (int j = 0; j < ROW; j++) begin
            ctr_m[idx*ROW + j] = r_init_ctr;
          end
        end
      end
      // train the counter, shift the history
      slot = ctr_slot(idx, it.pc);
      c    = ctr_m[slot];
      if (it.taken) begin
        if (c != CTR_MAX) c = c + 2'd1;
      end else begin
        if (c != CTR_MIN) c = c - 2'd1;
      end
      ctr_m[slot]    = c;
      hrow           = r_global_hist ? 0 : idx;
      hm             = hist_mask();
      hist_m[hrow]   = HIST_W'(((32'(hist_m[hrow]) << 1) & hm) | 32'(it.taken));
      target_m[idx]  = it.target_pc;
    end
    res.branch_count = branches;
    res.flush_count  = flushes;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    set_defaults();
  end

  // channel monitor: config, results, then newly accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    bp_out_t want;
    bp_out_t got;
    if (!rst_ni) begin
      set_defaults();
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        apply_reg_write(cfg_idx_i, cfg_data_i);
      end
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %h",
                   $time, result_i);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("predict_taken", 32'(want.predict_taken), 32'(result_i.predict_taken));
          check_field("next_pc", want.next_pc, result_i.next_pc);
          check_field("branch_count", want.branch_count, result_i.branch_count);
          check_field("flush_count", want.flush_count, result_i.flush_count);
        end
      end
      if (start_i && !busy_i) begin
        resolve_item(item_i, got);
        outcome_q.push_back(got);
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// File: bench/tb_btb_two_level_branch_predictor_top.sv
// testbench top: stimulus for the two-level branch predictor and the final verdict
module tb_btb_two_level_branch_predictor_top
  import btb2l_pkg::*;
();

  localparam int          NPHASE    = 8;
  localparam int          PHASE_LEN = 88;
  localparam int          POOL      = 10;
  localparam int unsigned LIMIT     = 300000;

  // index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  bp_in_t                item = '0;
  logic                  done;
  bp_out_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           pending;
  int unsigned           fails;
  int unsigned           cycle_cnt = 0;
  int unsigned           idle_pct = 0;

  // branch pool for well-formed predict/update pairs
  logic [31:0] pool_pc  [POOL];
  logic [31:0] pool_tgt [POOL];
  logic [7:0]  pool_pat [POOL];
  int unsigned pool_len [POOL];
  int unsigned pool_pos [POOL];

  btb_two_level_branch_predictor_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .item_i     (item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  btb_two_level_branch_predictor_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .done_i       (done),
    .result_i     (result),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bp_in_t make_item(input logic k, input logic [31:0] pc,
                                       input logic [31:0] tgt, input logic tk,
                                       input logic [31:0] pdst);
    bp_in_t it;
    it.kind          = k;
    it.pc            = pc;
    it.target_pc     = tgt;
    it.taken         = tk;
    it.predicted_dst = pdst;
    return it;
  endfunction

  // offer one item until accepted, then maybe idle for a burst
  task automatic send(input bp_in_t it);
    logic [127:0] junk;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      junk  = {$urandom, $urandom, $urandom, $urandom};
      start <= 1'b0;
      item  <= junk[$bits(bp_in_t)-1:0];
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= ri;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [4:0] ib, input logic [4:0] hl,
                              input logic [4:0] tb, input logic [4:0] ic,
                              input logic [4:0] gh, input logic [4:0] gt,
                              input logic [4:0] sm);
    poke_reg(REG_INDEX_BITS, ib);
    poke_reg(REG_HISTORY_LENGTH, hl);
    poke_reg(REG_TAG_BITS, tb);
    poke_reg(REG_INITIAL_CTR, ic);
    poke_reg(REG_GLOBAL_HISTORY, gh);
    poke_reg(REG_GLOBAL_TABLE, gt);
    poke_reg(REG_SHARE_MODE, sm);
  endtask

  // branches that alias in index and tag, some sharing high pc bits
  task automatic fill_pool();
    logic [31:0] hi;
    for (int i = 0; i < POOL; i++) begin
      hi          = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom_range(0, 255));
      pool_pc[i]  = (hi << 16) | (32'($urandom_range(0, 3)) << 7) |
                    (32'($urandom_range(0, 7)) << 2) | 32'($urandom_range(0, 3));
      pool_tgt[i] = $urandom;
      pool_pat[i] = $urandom_range(0, 255);
      pool_len[i] = $urandom_range(1, 8);
      pool_pos[i] = 0;
    end
  endtask

  // predict then resolve one pool branch following its outcome pattern
  task automatic branch_pair();
    int unsigned i;
    logic        tk;
    logic [31:0] pc;
    logic [31:0] pdst;
    i           = $urandom_range(0, POOL-1);
    pc          = pool_pc[i];
    tk          = pool_pat[i][pool_pos[i]];
    pool_pos[i] = (pool_pos[i] + 1) % pool_len[i];
    if ($urandom_range(0, 7) == 0) pool_tgt[i] = $urandom;
    case ($urandom_range(0, 3))
      0:       pdst = pool_tgt[i];
      1:       pdst = pc + PC_STEP;
      2:       pdst = tk ? pool_tgt[i] : pc + PC_STEP;
      default: pdst = $urandom;
    endcase
    send(make_item(KIND_PREDICT, pc, $urandom, 1'($urandom_range(0, 1)), $urandom));
    send(make_item(KIND_UPDATE, pc, pool_tgt[i], tk, pdst));
  endtask

  task automatic run_random(input int n);
    int cnt;
    int r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        branch_pair();
        cnt += 2;
      end else if (r < 85) begin
        send(make_item(KIND_UPDATE, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom));
        cnt++;
      end else begin
        send(make_item(KIND_PREDICT, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom));
        cnt++;
      end
    end
  endtask

  // directed items under the reset configuration
  task automatic directed_items();
    send(make_item(KIND_PREDICT, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send(make_item(KIND_UPDATE, 32'h0, 32'h100, 1'b1, 32'h4));
    send(make_item(KIND_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0));
    // saturate up, then down
    repeat (4) send(make_item(KIND_UPDATE, 32'h0, 32'h100, 1'b1, 32'h100));
    send(make_item(KIND_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0));
    repeat (4) send(make_item(KIND_UPDATE, 32'h0, 32'h100, 1'b0, 32'h4));
    send(make_item(KIND_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0));
    // same index, other tag evicts the entry
    send(make_item(KIND_UPDATE, 32'h80, 32'h200, 1'b1, 32'h0));
    send(make_item(KIND_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0));
    send(make_item(KIND_PREDICT, 32'h80, 32'h0, 1'b0, 32'h0));
    // pc plus four wrapping past the top of the address space
    send(make_item(KIND_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0));
    send(make_item(KIND_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0));
    send(make_item(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send(make_item(KIND_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0));
    // last index
    send(make_item(KIND_UPDATE, 32'h7C, 32'h0, 1'b1, 32'h0));
    send(make_item(KIND_PREDICT, 32'h7C, 32'h0, 1'b0, 32'h0));
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NPHASE; p++) begin
      idle_pct = (p == NPHASE-1 || p % 3 == 2) ? 0 : 35;
      if (p > 0) begin
        drain();
      end
      case (p)
        0: ;
        1: program_regs(5'd0, 5'd1, 5'd0, 5'd0, 5'd1, 5'd1, 5'(SHARE_LO));
        2: program_regs(5'd7, 5'd15, 5'd31, 5'd3, 5'd0, 5'd0, 5'(SHARE_HI));
        3: program_regs(5'd2, 5'd0, 5'd4, 5'd2, 5'd0, 5'd1, 5'd3);
        4: program_regs(5'd3, 5'd4, 5'd8, 5'd1, 5'd1, 5'd0, 5'(SHARE_LO));
        5: program_regs(5'd5, 5'd8, 5'd30, 5'd2, 5'd0, 5'd0, 5'(SHARE_HI));
        6: program_regs(5'd1, 5'd3, 5'd2, 5'd3, 5'd1, 5'd1, 5'(SHARE_NONE));
        default: program_regs(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)));
      endcase
      fill_pool();
      if (p == 0) begin
        directed_items();
      end
      run_random(PHASE_LEN / 2);
      // a write past the register list must leave the tables alone
      drain();
      poke_reg(REG_UNUSED, 5'($urandom_range(0, 31)));
      run_random(PHASE_LEN - PHASE_LEN / 2);
    end
    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
